FILE: rtl/rau_pkg.sv
package rau_pkg;

	// Operand width; each input field carries one operand
	localparam int OPERAND_WIDTH = 16;
	// Magnitude of a cross product or of the raw numerator
	localparam int PRODW = 2 * OPERAND_WIDTH;
	// Bit counter wide enough for one divider pass or a trailing-zero shift count
	localparam int CNTW = $clog2(PRODW);
	// Result field widths
	localparam int RES_NUM_W = 33;
	localparam int RES_DEN_W = 32;
	// Working width for sign application before truncation to the result fields
	localparam int EXTW = (PRODW + 1 > RES_NUM_W) ? PRODW + 1 : RES_NUM_W;

	// Operation codes on the func field
	typedef enum logic [1:0] {
		FUNC_ADD = 2'd0,
		FUNC_SUB = 2'd1,
		FUNC_MUL = 2'd2,
		FUNC_DIV = 2'd3
	} func_t;

	// Datapath operations issued by the sequencer
	typedef enum logic [3:0] {
		OP_NONE,
		OP_CAPTURE,
		OP_MUL_A,
		OP_MUL_B,
		OP_MUL_D,
		OP_COMBINE,
		OP_GCD_LOAD,
		OP_GCD_TZ,
		OP_GCD_STEP,
		OP_DIV_LOAD_N,
		OP_DIV_STEP,
		OP_DIV_LOAD_D,
		OP_DIV_STORE_D,
		OP_OUT_LOAD
	} dp_op_t;

	typedef struct packed {
		dp_op_t op;
	} dp_cmd_t;

	typedef struct packed {
		logic n_zero;
		logic d_zero;
		logic tz_done;
		logic gcd_done;
	} dp_stat_t;

endpackage

FILE: rtl/rau_in_if.sv
interface rau_in_if;

	logic                                       valid;
	logic                                       ready;
	logic [1:0]                                 func;
	logic signed [rau_pkg::OPERAND_WIDTH-1:0]   a_num;
	logic signed [rau_pkg::OPERAND_WIDTH-1:0]   a_den;
	logic signed [rau_pkg::OPERAND_WIDTH-1:0]   b_num;
	logic signed [rau_pkg::OPERAND_WIDTH-1:0]   b_den;

	modport source (output valid, output func, output a_num, output a_den,
		output b_num, output b_den, input ready);
	modport sink (input valid, input func, input a_num, input a_den,
		input b_num, input b_den, output ready);

endinterface

FILE: rtl/rau_out_if.sv
interface rau_out_if;

	logic                                   valid;
	logic                                   ready;
	logic signed [rau_pkg::RES_NUM_W-1:0]   res_num;
	logic signed [rau_pkg::RES_DEN_W-1:0]   res_den;
	logic                                   error;

	modport source (output valid, output res_num, output res_den, output error,
		input ready);
	modport sink (input valid, input res_num, input res_den, input error,
		output ready);

endinterface

FILE: rtl/rational_arithmetic_unit_top.sv
// Channel    Dir  Payload                              Transfer
// operands   in   func, a_num, a_den, b_num, b_den     valid && ready
// result     out  res_num, res_den, error              valid && ready
//
// One item at a time; ready is high only while the sequencer is idle.
// An item whose result numerator or denominator is zero skips the reduction;
// otherwise trailing zeros shared by both values are removed, the binary GCD
// loop runs, and two restoring divisions divide the numerator and then the
// denominator by the GCD.
// Reset only clears the sequencer and the result valid; no clearing pass.
// A stalled result waits in its own register; a new item is taken meanwhile.
module rational_arithmetic_unit_top (
	input  logic        clk,
	input  logic        arst_n,
	rau_in_if.sink      operands,
	rau_out_if.source   result
);

	rau_pkg::dp_cmd_t   cmd;
	rau_pkg::dp_stat_t  stat;

	// sequencer
	rau_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (operands.valid),
		.in_ready  (operands.ready),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.cmd       (cmd),
		.stat      (stat)
	);

	// multiplier, GCD and divider datapath
	rau_dp u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.func    (operands.func),
		.a_num   (operands.a_num),
		.a_den   (operands.a_den),
		.b_num   (operands.b_num),
		.b_den   (operands.b_den),
		.cmd     (cmd),
		.stat    (stat),
		.res_num (result.res_num),
		.res_den (result.res_den),
		.error   (result.error)
	);

endmodule

FILE: rtl/rau_dp.sv
module rau_dp (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  logic [1:0]                                func,
	input  logic signed [rau_pkg::OPERAND_WIDTH-1:0]  a_num,
	input  logic signed [rau_pkg::OPERAND_WIDTH-1:0]  a_den,
	input  logic signed [rau_pkg::OPERAND_WIDTH-1:0]  b_num,
	input  logic signed [rau_pkg::OPERAND_WIDTH-1:0]  b_den,
	input  rau_pkg::dp_cmd_t                          cmd,
	output rau_pkg::dp_stat_t                         stat,
	output logic signed [rau_pkg::RES_NUM_W-1:0]      res_num,
	output logic signed [rau_pkg::RES_DEN_W-1:0]      res_den,
	output logic                                      error
);

	localparam int W = rau_pkg::OPERAND_WIDTH;
	localparam int PW = rau_pkg::PRODW;
	localparam int XW = rau_pkg::EXTW;

	// two's complement to magnitude; the most negative value maps onto 2^(W-1)
	function automatic logic [W-1:0] mag_of(input logic [W-1:0] x);
		mag_of = x[W-1] ? (~x + 1'b1) : x;
	endfunction

	rau_pkg::func_t func_q;
	logic [W-1:0] an_m_q, ad_m_q, bn_m_q, bd_m_q;
	logic         an_s_q, ad_s_q, bn_s_q, bd_s_q;

	// sign-magnitude numerator, second cross term and denominator
	logic [PW-1:0] n_mag_q, p_mag_q, d_mag_q;
	logic          n_neg_q, p_neg_q, d_neg_q;

	// binary GCD working registers
	logic [PW-1:0]                u_q, v_q;
	logic [rau_pkg::CNTW-1:0]     k_q;

	// restoring divider
	logic [PW-1:0] g_q, rem_q, quot_q;

	// result register
	logic signed [rau_pkg::RES_NUM_W-1:0] res_num_q;
	logic signed [rau_pkg::RES_DEN_W-1:0] res_den_q;
	logic                                 error_q;

	// shared multiplier operand selection
	logic [W-1:0]  ma, mb;
	logic          sa, sb;
	logic [PW-1:0] prod;
	logic          prod_nz, prod_neg;

	always_comb begin
		case (cmd.op)
			rau_pkg::OP_MUL_A: begin
				ma = an_m_q;
				sa = an_s_q;
				mb = (func_q == rau_pkg::FUNC_MUL) ? bn_m_q : bd_m_q;
				sb = (func_q == rau_pkg::FUNC_MUL) ? bn_s_q : bd_s_q;
			end
			rau_pkg::OP_MUL_B: begin
				ma = ad_m_q;
				sa = ad_s_q;
				mb = bn_m_q;
				sb = bn_s_q;
			end
			default: begin
				ma = ad_m_q;
				sa = ad_s_q;
				mb = (func_q == rau_pkg::FUNC_DIV) ? bn_m_q : bd_m_q;
				sb = (func_q == rau_pkg::FUNC_DIV) ? bn_s_q : bd_s_q;
			end
		endcase
	end

	assign prod     = {{W{1'b0}}, ma} * {{W{1'b0}}, mb};
	assign prod_nz  = (prod != '0);
	assign prod_neg = (sa ^ sb) && prod_nz;

	// sign-magnitude add of the two cross terms
	logic [PW-1:0] sum_mag, n_minus_p, p_minus_n, comb_mag;
	logic          n_ge_p, comb_neg;

	always_comb begin
		sum_mag   = n_mag_q + p_mag_q;
		n_minus_p = n_mag_q - p_mag_q;
		p_minus_n = p_mag_q - n_mag_q;
		n_ge_p    = (n_mag_q >= p_mag_q);
		if (n_neg_q == p_neg_q) begin
			comb_mag = sum_mag;
			comb_neg = n_neg_q;
		end else if (n_ge_p) begin
			comb_mag = n_minus_p;
			comb_neg = n_neg_q;
		end else begin
			comb_mag = p_minus_n;
			comb_neg = p_neg_q;
		end
		if (comb_mag == '0) begin
			comb_neg = 1'b0;
		end
	end

	// GCD step: compare and subtract of the two odd values
	logic [PW:0]   uv_diff;
	logic [PW-1:0] vu_diff;
	logic          u_gt_v;

	always_comb begin
		uv_diff = {1'b0, u_q} - {1'b0, v_q};
		vu_diff = v_q - u_q;
		u_gt_v  = !uv_diff[PW] && (uv_diff[PW-1:0] != '0);
	end

	// divider trial subtract
	logic [PW:0] trial, trial_diff;
	logic        q_bit;

	always_comb begin
		trial      = {rem_q, quot_q[PW-1]};
		trial_diff = trial - {1'b0, g_q};
		q_bit      = !trial_diff[PW];
	end

	// status to the sequencer
	always_comb begin
		stat.n_zero   = (n_mag_q == '0);
		stat.d_zero   = (d_mag_q == '0);
		stat.tz_done  = u_q[0] | v_q[0];
		stat.gcd_done = (v_q == '0);
	end

	// signed result values, truncated to the field widths
	logic [XW-1:0] num_ext, den_ext, num_sv, den_sv;
	logic [PW-1:0] den_mag;

	always_comb begin
		den_mag = stat.n_zero ? PW'(1) : d_mag_q;
		num_ext = {{(XW-PW){1'b0}}, n_mag_q};
		den_ext = {{(XW-PW){1'b0}}, den_mag};
		num_sv  = n_neg_q ? (~num_ext + 1'b1) : num_ext;
		den_sv  = d_neg_q ? (~den_ext + 1'b1) : den_ext;
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (cmd.op)
			rau_pkg::OP_CAPTURE: begin
				func_q <= rau_pkg::func_t'(func);
				an_m_q <= mag_of(a_num);
				ad_m_q <= mag_of(a_den);
				bn_m_q <= mag_of(b_num);
				bd_m_q <= mag_of(b_den);
				an_s_q <= a_num[W-1];
				ad_s_q <= a_den[W-1];
				bn_s_q <= b_num[W-1];
				bd_s_q <= b_den[W-1];
			end
			rau_pkg::OP_MUL_A: begin
				n_mag_q <= prod;
				n_neg_q <= prod_neg;
			end
			rau_pkg::OP_MUL_B: begin
				p_mag_q <= prod;
				p_neg_q <= prod_neg ^ ((func_q == rau_pkg::FUNC_SUB) && prod_nz);
			end
			rau_pkg::OP_MUL_D: begin
				d_mag_q <= prod;
				d_neg_q <= prod_neg;
			end
			rau_pkg::OP_COMBINE: begin
				if (func_q == rau_pkg::FUNC_ADD || func_q == rau_pkg::FUNC_SUB) begin
					n_mag_q <= comb_mag;
					n_neg_q <= comb_neg;
				end
			end
			rau_pkg::OP_GCD_LOAD: begin
				u_q <= n_mag_q;
				v_q <= d_mag_q;
				k_q <= '0;
			end
			rau_pkg::OP_GCD_TZ: begin
				if (!stat.tz_done) begin
					u_q <= u_q >> 1;
					v_q <= v_q >> 1;
					k_q <= k_q + 1'b1;
				end
			end
			rau_pkg::OP_GCD_STEP: begin
				if (!stat.gcd_done) begin
					if (!u_q[0]) begin
						u_q <= u_q >> 1;
					end else if (!v_q[0]) begin
						v_q <= v_q >> 1;
					end else if (u_gt_v) begin
						u_q <= v_q;
						v_q <= uv_diff[PW-1:0];
					end else begin
						v_q <= vu_diff;
					end
				end
			end
			rau_pkg::OP_DIV_LOAD_N: begin
				g_q    <= u_q << k_q;
				quot_q <= n_mag_q;
				rem_q  <= '0;
			end
			rau_pkg::OP_DIV_STEP: begin
				rem_q  <= q_bit ? trial_diff[PW-1:0] : trial[PW-1:0];
				quot_q <= {quot_q[PW-2:0], q_bit};
			end
			rau_pkg::OP_DIV_LOAD_D: begin
				n_mag_q <= quot_q;
				quot_q  <= d_mag_q;
				rem_q   <= '0;
			end
			rau_pkg::OP_DIV_STORE_D: begin
				d_mag_q <= quot_q;
			end
			rau_pkg::OP_OUT_LOAD: begin
				error_q   <= stat.d_zero;
				res_num_q <= stat.d_zero ? '0 : num_sv[rau_pkg::RES_NUM_W-1:0];
				res_den_q <= stat.d_zero ? '0 : den_sv[rau_pkg::RES_DEN_W-1:0];
			end
			default: begin
			end
		endcase
	end

	assign res_num = res_num_q;
	assign res_den = res_den_q;
	assign error   = error_q;

	// gcd is never zero when division starts
	a_gcd_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op == rau_pkg::OP_DIV_LOAD_N |-> u_q != '0)
		else $error("gcd is zero at divider start");

	// reduction divides exactly: no remainder after either pass
	a_num_exact: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op == rau_pkg::OP_DIV_LOAD_D |-> rem_q == '0)
		else $error("numerator not divisible by gcd");

	a_den_exact: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op == rau_pkg::OP_DIV_STORE_D |-> rem_q == '0)
		else $error("denominator not divisible by gcd");

endmodule

FILE: rtl/rau_ctrl.sv
module rau_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	output logic               out_valid,
	input  logic               out_ready,
	output rau_pkg::dp_cmd_t   cmd,
	input  rau_pkg::dp_stat_t  stat
);

	localparam logic [rau_pkg::CNTW-1:0] DIV_LAST = rau_pkg::CNTW'(rau_pkg::PRODW - 1);

	typedef enum logic [3:0] {
		S_IDLE,
		S_MUL_A,
		S_MUL_B,
		S_MUL_D,
		S_COMB,
		S_CHECK,
		S_TZ,
		S_RUN,
		S_DIVN_LD,
		S_DIVN,
		S_DIVD_LD,
		S_DIVD,
		S_DIVD_ST,
		S_FINISH
	} state_t;

	state_t                    state_q;
	logic [rau_pkg::CNTW-1:0]  cnt_q;
	logic                      out_valid_q;
	logic                      out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	// operation decode per state
	always_comb begin
		case (state_q)
			S_IDLE:    cmd.op = in_valid ? rau_pkg::OP_CAPTURE : rau_pkg::OP_NONE;
			S_MUL_A:   cmd.op = rau_pkg::OP_MUL_A;
			S_MUL_B:   cmd.op = rau_pkg::OP_MUL_B;
			S_MUL_D:   cmd.op = rau_pkg::OP_MUL_D;
			S_COMB:    cmd.op = rau_pkg::OP_COMBINE;
			S_CHECK:   cmd.op = (stat.d_zero || stat.n_zero) ? rau_pkg::OP_NONE
				: rau_pkg::OP_GCD_LOAD;
			S_TZ:      cmd.op = rau_pkg::OP_GCD_TZ;
			S_RUN:     cmd.op = rau_pkg::OP_GCD_STEP;
			S_DIVN_LD: cmd.op = rau_pkg::OP_DIV_LOAD_N;
			S_DIVN:    cmd.op = rau_pkg::OP_DIV_STEP;
			S_DIVD_LD: cmd.op = rau_pkg::OP_DIV_LOAD_D;
			S_DIVD:    cmd.op = rau_pkg::OP_DIV_STEP;
			S_DIVD_ST: cmd.op = rau_pkg::OP_DIV_STORE_D;
			S_FINISH:  cmd.op = out_free ? rau_pkg::OP_OUT_LOAD : rau_pkg::OP_NONE;
			default:   cmd.op = rau_pkg::OP_NONE;
		endcase
	end

	// sequencer state, divider bit count and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_MUL_A;
					end
				end
				S_MUL_A: state_q <= S_MUL_B;
				S_MUL_B: state_q <= S_MUL_D;
				S_MUL_D: state_q <= S_COMB;
				S_COMB:  state_q <= S_CHECK;
				S_CHECK: begin
					state_q <= (stat.d_zero || stat.n_zero) ? S_FINISH : S_TZ;
				end
				S_TZ: begin
					if (stat.tz_done) begin
						state_q <= S_RUN;
					end
				end
				S_RUN: begin
					if (stat.gcd_done) begin
						state_q <= S_DIVN_LD;
					end
				end
				S_DIVN_LD: begin
					cnt_q   <= '0;
					state_q <= S_DIVN;
				end
				S_DIVN: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == DIV_LAST) begin
						state_q <= S_DIVD_LD;
					end
				end
				S_DIVD_LD: begin
					cnt_q   <= '0;
					state_q <= S_DIVD;
				end
				S_DIVD: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == DIV_LAST) begin
						state_q <= S_DIVD_ST;
					end
				end
				S_DIVD_ST: state_q <= S_FINISH;
				S_FINISH: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// an accepted item always starts at the first multiply
	a_start: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> state_q == S_MUL_A)
		else $error("accepted item did not start");

	// a loaded result is presented on the next cycle
	a_out_load: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op == rau_pkg::OP_OUT_LOAD |=> out_valid_q)
		else $error("result loaded without valid");

	// the output register is never overwritten while still held
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op == rau_pkg::OP_OUT_LOAD |-> !out_valid_q || out_ready)
		else $error("pending result overwritten");

endmodule

FILE: bench/rational_arithmetic_unit_top_tb.sv
module rational_arithmetic_unit_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import rau_pkg::*;

	typedef logic signed [OPERAND_WIDTH-1:0] operand_t;

	typedef struct packed {
		logic signed [RES_NUM_W-1:0] num;
		logic signed [RES_DEN_W-1:0] den;
		logic                        err;
	} fraction_t;

	localparam int RANDOM_ITEMS = 780;
	localparam int CYCLE_LIMIT  = 1000000;
	localparam int HOLD_CYCLES  = 800;
	localparam int HOLD_AFTER   = 250;
	localparam int DRAIN_CYCLES = 250;

	// Expected reduced fractions, oldest first, with the checks against them
	class fraction_scoreboard;
		fraction_t expected_q[$];
		int mismatches;
		int results;
		int per_func[4];
		int zero_dens;
		int zero_nums;

		// Cross products, then Euclid on the magnitudes; signs left where they fall
		function fraction_t reduce_fraction(func_t f, operand_t an, operand_t ad,
			operand_t bn, operand_t bd);
			longint n, d, x, y, t;
			longint a_n, a_d, b_n, b_d;
			fraction_t r;
			a_n = an;
			a_d = ad;
			b_n = bn;
			b_d = bd;
			case (f)
				FUNC_ADD: begin
					n = a_n * b_d + a_d * b_n;
					d = a_d * b_d;
				end
				FUNC_SUB: begin
					n = a_n * b_d - a_d * b_n;
					d = a_d * b_d;
				end
				FUNC_MUL: begin
					n = a_n * b_n;
					d = a_d * b_d;
				end
				default: begin
					n = a_n * b_d;
					d = a_d * b_n;
				end
			endcase
			if (d == 0) begin
				r.num = '0;
				r.den = '0;
				r.err = 1'b1;
				return r;
			end
			x = (n < 0) ? -n : n;
			y = (d < 0) ? -d : d;
			while (y != 0) begin
				t = x % y;
				x = y;
				y = t;
			end
			// a zero numerator gives x = |d| here, so d reduces to its sign
			n = n / x;
			d = d / x;
			r.num = n[RES_NUM_W-1:0];
			r.den = d[RES_DEN_W-1:0];
			r.err = 1'b0;
			return r;
		endfunction

		function void note_operands(func_t f, operand_t an, operand_t ad,
			operand_t bn, operand_t bd);
			fraction_t want;
			want = reduce_fraction(f, an, ad, bn, bd);
			per_func[int'(f)]++;
			if (want.err)
				zero_dens++;
			else if (want.num == 0)
				zero_nums++;
			expected_q.push_back(want);
		endfunction

		function void check_result(fraction_t got);
			fraction_t want;
			if (expected_q.size() == 0) begin
				$error("result transfer with nothing pending: res_num %0d res_den %0d error %0b",
					got.num, got.den, got.err);
				mismatches++;
				return;
			end
			want = expected_q.pop_front();
			results++;
			if (got.err !== want.err) begin
				$error("error: expected %0b, actual %0b", want.err, got.err);
				mismatches++;
			end
			if (got.num !== want.num) begin
				$error("res_num: expected %0d, actual %0d", want.num, got.num);
				mismatches++;
			end
			if (got.den !== want.den) begin
				$error("res_den: expected %0d, actual %0d", want.den, got.den);
				mismatches++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	int   cycles = 0;
	int   burst_left = 0;
	fraction_scoreboard sb;

	rau_in_if  operands();
	rau_out_if result();

	rational_arithmetic_unit_top dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.operands (operands),
		.result   (result)
	);

	always #4 clk = ~clk;

	// Watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Timed out after %0d cycles, %0d results pending",
				cycles, sb.expected_q.size());
			$display("Simulation FAILED");
			$finish;
		end
	end

	// Operand mix: mostly small values and shared factors so that GCDs bite,
	// plus full-range words and the corners of the range
	function automatic operand_t pick_operand();
		logic [31:0] raw;
		int v;
		raw = $urandom();
		case ($urandom_range(0, 9))
			0, 1, 2, 3: v = int'($urandom_range(0, 40)) - 20;
			4, 5:       v = int'($urandom_range(0, 2000)) - 1000;
			6, 7:       v = int'(raw[15:0]);
			8: begin
				case ($urandom_range(0, 5))
					0:       v = -32768;
					1:       v = -32767;
					2:       v = -1;
					3:       v = 0;
					4:       v = 1;
					default: v = 32767;
				endcase
			end
			default: begin
				v = int'($urandom_range(1, 180)) * 180;
				if (raw[16])
					v = -v;
			end
		endcase
		return operand_t'(v);
	endfunction

	// Bursts of back-to-back items separated by gaps of random length
	task automatic pace_sender();
		int gap;
		if (burst_left > 0) begin
			burst_left--;
			return;
		end
		gap = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 160) : $urandom_range(0, 8);
		burst_left = $urandom_range(1, 30);
		if (gap != 0) begin
			operands.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic send_operands(func_t f, operand_t an, operand_t ad,
		operand_t bn, operand_t bd);
		operands.valid <= 1'b1;
		operands.func  <= f;
		operands.a_num <= an;
		operands.a_den <= ad;
		operands.b_num <= bn;
		operands.b_den <= bd;
		do @(posedge clk); while (operands.ready !== 1'b1);
		sb.note_operands(f, an, ad, bn, bd);
		pace_sender();
	endtask

	// Corners, every operation, zero denominators and zero numerators
	task automatic run_directed();
		send_operands(FUNC_ADD, 1, 2, 1, 3);
		send_operands(FUNC_SUB, 1, 2, 1, 2);
		send_operands(FUNC_MUL, -3, 4, 4, -3);
		send_operands(FUNC_DIV, 2, 3, 0, 5);
		send_operands(FUNC_ADD, 1, 0, 1, 1);
		send_operands(FUNC_SUB, 0, 0, 0, 0);
		send_operands(FUNC_MUL, 0, -7, 5, 3);
		send_operands(FUNC_ADD, 0, 5, 0, -3);
		send_operands(FUNC_DIV, 7, 1, 0, 1);
		send_operands(FUNC_ADD, -32768, -32768, -32768, -32768);
		send_operands(FUNC_SUB, 32767, -32768, -32768, 32767);
		send_operands(FUNC_MUL, -32768, 32767, -32768, 32767);
		send_operands(FUNC_DIV, 32767, -32768, 32767, -32768);
		send_operands(FUNC_ADD, -32768, 32767, -32768, 32767);
		send_operands(FUNC_ADD, -1, -1, -1, -1);
		send_operands(FUNC_DIV, -32768, 1, 1, -32768);
		send_operands(FUNC_MUL, 32767, 1, 32767, 1);
		send_operands(FUNC_SUB, 1, -32768, 1, 32767);
		send_operands(FUNC_SUB, -32768, 1, 32767, 1);
		send_operands(FUNC_DIV, 1, 32767, -32768, 1);
	endtask

	// Result side: check each transfer, stall on a pattern of its own and
	// hold off once for a long stretch so that the block backs up
	initial begin
		int mode;
		int mode_left;
		int hold_left;
		bit held;
		fraction_t got;
		mode = 0;
		mode_left = 0;
		hold_left = 0;
		held = 1'b0;
		result.ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (result.valid === 1'b1 && result.ready === 1'b1) begin
				got.num = result.res_num;
				got.den = result.res_den;
				got.err = result.error;
				sb.check_result(got);
			end
			if (!held && sb.results >= HOLD_AFTER) begin
				held = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (mode_left == 0) begin
				mode = $urandom_range(0, 2);
				mode_left = $urandom_range(50, 600);
			end
			mode_left--;
			if (hold_left > 0) begin
				hold_left--;
				result.ready <= 1'b0;
			end else begin
				case (mode)
					0:       result.ready <= 1'b1;
					1:       result.ready <= ($urandom_range(0, 1) == 1);
					default: result.ready <= ($urandom_range(0, 4) == 0);
				endcase
			end
		end
	end

	// Reset, stimulus, drain and verdict
	initial begin
		sb = new();
		arst_n <= 1'b0;
		operands.valid <= 1'b0;
		operands.func  <= FUNC_ADD;
		operands.a_num <= '0;
		operands.a_den <= '0;
		operands.b_num <= '0;
		operands.b_den <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		run_directed();
		repeat (RANDOM_ITEMS)
			send_operands(func_t'($urandom_range(0, 3)), pick_operand(), pick_operand(),
				pick_operand(), pick_operand());
		operands.valid <= 1'b0;

		while (sb.expected_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Checked %0d results: add %0d, subtract %0d, multiply %0d, divide %0d.",
			sb.results, sb.per_func[0], sb.per_func[1], sb.per_func[2], sb.per_func[3]);
		$display("%0d zero-denominator errors, %0d zero numerators, %0d mismatches.",
			sb.zero_dens, sb.zero_nums, sb.mismatches);
		if (sb.mismatches == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
